/* rtl/fdi_pkg.sv */
// Package for the forward difference interpolator: sizes, action and status codes,
// and the saturation helper. It depends on nothing else.
package fdi_pkg;

  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned D_W        = 24;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned ACC_W      = 60;
  localparam int unsigned Y_W        = 48;
  localparam int unsigned DVD_W      = 48;
  localparam int unsigned DVS_W      = 16;
  localparam int unsigned ITER_W     = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FEW    = 3'd1,
    ST_ZERO_H = 3'd2,
    ST_FULL   = 3'd3,
    ST_SAT    = 3'd4
  } status_e;

  // Applies a sign to a quotient magnitude and saturates it to 32 bits signed.
  // Bit Q_W of the return value is the saturation flag.
  function automatic logic [Q_W:0] sat32(input logic [DVD_W-1:0] mag, input logic neg);
    logic          big;
    logic          is_min;
    logic [Q_W:0]  r;
    big    = |mag[DVD_W-1:Q_W-1];
    is_min = neg && (mag == {{(DVD_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}});
    if (big && !is_min) begin
      r = neg ? {1'b1, 1'b1, {(Q_W-1){1'b0}}} : {1'b1, 1'b0, {(Q_W-1){1'b1}}};
    end else begin
      r = {1'b0, (neg ? (~mag[Q_W-1:0] + 1'b1) : mag[Q_W-1:0])};
    end
    return r;
  endfunction

endpackage

/* rtl/fdi_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
// Used for both difference diagonals; no dependencies.
module fdi_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fdi_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on fdi_pkg for its widths.
module fdi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fdi_pkg::DVD_W-1:0] dividend_i,
  input  logic [fdi_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [fdi_pkg::DVD_W-1:0] quotient_o
);
  import fdi_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ITER_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/forward_difference_interpolator_core.sv */
// Newton forward-difference interpolator. Each transaction gives one result. Clear and
// the unknown action go straight to the output state, a load does one read-modify-write
// of the trailing diagonal per order, and an evaluation uses the shared 48-step divider
// to form u and then each product term.
module forward_difference_interpolator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic signed [23:0] query_x_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [47:0] result_y_o,
  output logic [2:0]  status_o
);
  import fdi_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_LD      = 10'b0000000010,
    S_EV_U    = 10'b0000000100,
    S_EV_MUL  = 10'b0000001000,
    S_EV_DST  = 10'b0000010000,
    S_EV_DW   = 10'b0000100000,
    S_EV_TERM = 10'b0001000000,
    S_EV_ACC  = 10'b0010000000,
    S_EV_FIN  = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [15:0]    x0_q, x0_d, x1_q, x1_d;
  logic [IDX_W-1:0]      k_q, k_d, n_q, n_d;
  logic [D_W-1:0]        cur_q, cur_d, prev_q, prev_d;
  logic [Q_W-1:0]        u_q, u_d, p_q, p_d;
  logic signed [64:0]    mt_q, mt_d;
  logic signed [55:0]    term_q, term_d;
  logic signed [ACC_W-1:0] y_q, y_d;
  logic                  sat_q, sat_d;
  logic                  neg_q, neg_d;
  logic [Y_W-1:0]        pres_q, pres_d;
  status_e               pst_q, pst_d;
  logic                  out_valid_q, out_valid_d;
  logic [Y_W-1:0]        res_q, res_d;
  status_e               st_q, st_d;

  logic                  acc;
  action_e               act;
  logic signed [16:0]    h;
  logic [16:0]           hmag;
  logic signed [24:0]    qdiff;
  logic signed [32:0]    num;
  logic [32:0]           nmag;
  logic signed [32:0]    t;
  logic [64:0]           mt_mag;
  logic [D_W-1:0]        cur_new;
  logic [Q_W:0]          qsat;
  logic [ACC_W-Y_W:0]    y_hi;

  logic                  div_start, div_busy, div_done;
  logic [DVD_W-1:0]      div_dvd, div_quo;
  logic [DVS_W-1:0]      div_dvs;

  logic                  tr_we, tr_re, ld_we, ld_re;
  logic [IDX_W-1:0]      tr_raddr, ld_raddr;
  logic [D_W-1:0]        tr_rdata, ld_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign act        = action_e'(action_i);

  assign h     = {x1_q[15], x1_q} - {x0_q[15], x0_q};
  assign hmag  = h[16] ? -h : h;
  assign qdiff = {query_x_i[23], query_x_i} - {x0_q[15], x0_q, 8'd0};
  assign num   = {qdiff, 8'd0};
  assign nmag  = num[32] ? -num : num;

  assign t      = {u_q[Q_W-1], u_q} - {14'd0, (k_q - 1'b1), 16'd0};
  assign mt_d   = $signed(p_q) * t;
  assign mt_mag = mt_q[64] ? -mt_q : mt_q;
  assign term_d = $signed(p_q) * $signed(ld_rdata);

  assign cur_new = (k_q == '0) ? cur_q : (cur_q - prev_q);
  assign qsat    = sat32(div_quo, neg_q);
  assign y_hi    = y_q[ACC_W-1:Y_W-1];

  // The divider serves u at evaluation start and each product term afterwards.
  assign div_start = (acc && act == ACT_EVAL && cnt_q >= CNT_W'(2) && h != '0)
                     || (state_q == S_EV_DST);
  assign div_dvd   = (state_q == S_IDLE) ? {{(DVD_W-33){1'b0}}, nmag} : mt_mag[63:16];
  assign div_dvs   = (state_q == S_IDLE) ? hmag[DVS_W-1:0]
                                         : {{(DVS_W-IDX_W){1'b0}}, k_q};

  assign tr_we    = (state_q == S_LD);
  assign tr_re    = (acc && act == ACT_LOAD) || (state_q == S_LD && k_q != n_q);
  assign tr_raddr = (state_q == S_IDLE) ? '0 : (k_q + 1'b1);
  assign ld_we    = (state_q == S_LD) && (k_q == n_q);
  assign ld_re    = (acc && act == ACT_EVAL) || (state_q == S_EV_MUL);
  assign ld_raddr = (state_q == S_IDLE) ? '0 : k_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    k_d         = k_q;
    n_d         = n_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    u_d         = u_q;
    p_d         = p_q;
    y_d         = y_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    pres_d      = pres_q;
    pst_d       = pst_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    st_d        = st_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (div_start) begin
      neg_d = (state_q == S_IDLE) ? (num[32] ^ h[16]) : mt_q[64];
    end

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          pres_d  = '0;
          pst_d   = ST_OK;
          state_d = S_OUT;
          case (act)
            ACT_CLEAR: cnt_d = '0;
            ACT_LOAD: begin
              if (cnt_q == CNT_W'(MAX_POINTS)) begin
                pst_d = ST_FULL;
              end else begin
                n_d   = cnt_q[IDX_W-1:0];
                k_d   = '0;
                cur_d = D_W'(sample_y_i);
                if (cnt_q == CNT_W'(0)) x0_d = sample_x_i;
                if (cnt_q == CNT_W'(1)) x1_d = sample_x_i;
                state_d = S_LD;
              end
            end
            ACT_EVAL: begin
              if (cnt_q < CNT_W'(2)) begin
                pst_d = ST_FEW;
              end else if (h == '0) begin
                pst_d = ST_ZERO_H;
              end else begin
                state_d = S_EV_U;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD: begin
        // One order per cycle: the next entry is read while this one is written.
        if (k_q == n_q) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_OUT;
        end else begin
          k_d    = k_q + 1'b1;
          cur_d  = cur_new;
          prev_d = tr_rdata;
        end
      end
      S_EV_U: begin
        if (div_done) begin
          u_d     = qsat[Q_W-1:0];
          sat_d   = qsat[Q_W];
          y_d     = {{(ACC_W-D_W-16){ld_rdata[D_W-1]}}, ld_rdata, 16'd0};
          p_d     = Q_W'(65536);
          k_d     = IDX_W'(1);
          state_d = S_EV_MUL;
        end
      end
      S_EV_MUL:  state_d = S_EV_DST;
      S_EV_DST:  state_d = S_EV_DW;
      S_EV_DW: begin
        if (div_done) begin
          p_d     = qsat[Q_W-1:0];
          sat_d   = sat_q | qsat[Q_W];
          state_d = S_EV_TERM;
        end
      end
      S_EV_TERM: state_d = S_EV_ACC;
      S_EV_ACC: begin
        y_d = y_q + {{(ACC_W-56){term_q[55]}}, term_q};
        if ((CNT_W'(k_q) + 1'b1) < cnt_q) begin
          k_d     = k_q + 1'b1;
          state_d = S_EV_MUL;
        end else begin
          state_d = S_EV_FIN;
        end
      end
      S_EV_FIN: begin
        if ((&y_hi) || !(|y_hi)) begin
          pres_d = y_q[Y_W-1:0];
          pst_d  = sat_q ? ST_SAT : ST_OK;
        end else begin
          pres_d = y_q[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
          pst_d  = ST_SAT;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_d       = pres_q;
          st_d        = pst_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      x0_q        <= x0_d;
      x1_q        <= x1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    n_q    <= n_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    u_q    <= u_d;
    p_q    <= p_d;
    mt_q   <= (state_q == S_EV_MUL) ? mt_d : mt_q;
    term_q <= (state_q == S_EV_TERM) ? term_d : term_q;
    y_q    <= y_d;
    sat_q  <= sat_d;
    neg_q  <= neg_d;
    pres_q <= pres_d;
    pst_q  <= pst_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

  fdi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  fdi_ram #(.DEPTH(MAX_POINTS), .WIDTH(D_W)) u_trail (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (k_q),
    .wdata_i (cur_new),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  fdi_ram #(.DEPTH(MAX_POINTS), .WIDTH(D_W)) u_lead (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (n_q),
    .wdata_i (cur_new),
    .re_i    (ld_re),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign result_y_o  = res_q;
  assign status_o    = st_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS)) else $error("point count beyond table size");

  a_load_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD) |-> (k_q <= n_q)) else $error("load step past new point");

  a_eval_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV_MUL) |-> (CNT_W'(k_q) < cnt_q)) else $error("order beyond loaded points");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

endmodule

/* test/tb_forward_difference_interpolator_core.sv */
// Self-checking testbench for forward_difference_interpolator_core. It predicts each
// result from its own model of the difference diagonals. Depends on rtl/fdi_pkg.sv.
module tb_forward_difference_interpolator_core;
  import fdi_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam longint Q_ONE      = 65536;
  localparam longint Y_HI       = 64'sd140737488355327;
  localparam longint Y_LO       = -64'sd140737488355328;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i = ACT_NOP;
  logic signed [15:0] sample_x_i = '0;
  logic signed [15:0] sample_y_i = '0;
  logic signed [23:0] query_x_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [47:0] result_y_o;
  logic [2:0]         status_o;

  forward_difference_interpolator_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Model state of the block.
  int     pts_loaded;
  longint x_first, x_second;
  longint lead_diag [MAX_POINTS];
  longint trail_diag[MAX_POINTS];

  logic signed [47:0] want_y[$];
  status_e            want_status[$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic longint wrap24(longint v);
    return {{40{v[23]}}, v[23:0]};
  endfunction

  function automatic longint clip32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Applies one accepted transaction to the model and queues the result it causes.
  task automatic predict_interpolation(action_e act, longint sx, longint sy, longint qx);
    longint  y, u, p, t, h, prev, cur, old;
    status_e st;
    bit      sat;
    y = 0;
    st = ST_OK;
    sat = 1'b0;
    case (act)
      ACT_CLEAR: pts_loaded = 0;
      ACT_LOAD: begin
        if (pts_loaded >= MAX_POINTS) begin
          st = ST_FULL;
        end else begin
          prev = trail_diag[0];
          cur = sy;
          if (pts_loaded == 0) x_first = sx;
          if (pts_loaded == 1) x_second = sx;
          trail_diag[0] = cur;
          for (int k = 1; k <= pts_loaded && k < MAX_POINTS; k++) begin
            old = trail_diag[k];
            cur = wrap24(cur - prev);
            trail_diag[k] = cur;
            prev = old;
          end
          lead_diag[pts_loaded] = trail_diag[pts_loaded];
          pts_loaded++;
        end
      end
      ACT_EVAL: begin
        h = x_second - x_first;
        if (pts_loaded < 2) begin
          st = ST_FEW;
        end else if (h == 0) begin
          st = ST_ZERO_H;
        end else begin
          u = clip32(((qx - x_first * 256) * 256) / h, sat);
          p = Q_ONE;
          y = lead_diag[0] * Q_ONE;
          for (int k = 1; k < pts_loaded && k < MAX_POINTS; k++) begin
            t = u - longint'(k - 1) * Q_ONE;
            p = clip32((p * t) / (Q_ONE * k), sat);
            y += p * lead_diag[k];
          end
          if (y > Y_HI) begin
            y = Y_HI;
            sat = 1'b1;
          end
          if (y < Y_LO) begin
            y = Y_LO;
            sat = 1'b1;
          end
          if (sat) st = ST_SAT;
        end
      end
      default: ;
    endcase
    want_y.push_back(y[47:0]);
    want_status.push_back(st);
  endtask

  // Offers one transaction and returns once it has been accepted.
  task automatic send_item(action_e act, logic [15:0] sx, logic [15:0] sy, logic [23:0] qx);
    int gap;
    if (!calm && $urandom_range(0, 99) < 13) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    sample_x_i <= sx;
    sample_y_i <= sy;
    query_x_i  <= qx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_interpolation(act, longint'(signed'(sx)), longint'(signed'(sy)),
                          longint'(signed'(qx)));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (want_y.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_few_points();
    send_item(ACT_CLEAR, 16'h0000, 16'h0000, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000100);
    send_item(ACT_LOAD, 16'h0005, 16'h0007, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000500);
  endtask

  task automatic test_zero_spacing();
    send_item(ACT_LOAD, 16'h0005, 16'hFFFF, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000600);
  endtask

  task automatic test_widest_spacing();
    send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_item(ACT_LOAD, 16'h8000, 16'h7FFF, 24'h000000);
    send_item(ACT_LOAD, 16'h7FFF, 16'h8000, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h7FFFFF);
  endtask

  // Fills the table with alternating extreme ordinates, overfills it, and evaluates
  // once inside the samples and twice far outside them, where the products saturate.
  task automatic test_full_table();
    send_item(ACT_CLEAR, 16'h0000, 16'h0000, 24'h000000);
    for (int i = 0; i < MAX_POINTS; i++)
      send_item(ACT_LOAD, 16'(i), (i % 2) ? 16'h8000 : 16'h7FFF, 24'h000000);
    send_item(ACT_LOAD, 16'h0009, 16'h1234, 24'h000000);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000380);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h7FFFFF);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h800000);
  endtask

  task automatic test_unknown_action();
    send_item(ACT_NOP, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'h000200);
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    calm = 1'b1;
    hold_left = 400;
    send_item(ACT_CLEAR, 16'h0000, 16'h0000, 24'h000000);
    for (int i = 0; i < 4; i++)
      send_item(ACT_LOAD, 16'(i * 2), 16'($urandom_range(0, 200) - 100), 24'h000000);
    for (int i = 0; i < 10; i++)
      send_item(ACT_EVAL, 16'h0000, 16'h0000, 24'($urandom_range(0, 2048)));
    wait_drained();
    calm = 1'b0;
  endtask

  // Random point sets, mostly well formed, with noise and broken sets mixed in.
  task automatic test_random_sets();
    int          n, h, x0, evals;
    logic [15:0] y;
    longint      qx;
    while (items_sent < RANDOM_ITEMS + 60) begin
      calm = (items_sent > 500 && items_sent < 700);
      if ($urandom_range(0, 9) == 0) wait_drained();
      send_item(ACT_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, MAX_POINTS);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
      x0 = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < n; i++) begin
        y = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
        send_item(ACT_LOAD, 16'(x0 + i * h), y, 24'($urandom));
      end
      if ($urandom_range(0, 7) == 0)
        send_item(ACT_LOAD, 16'($urandom), 16'($urandom), 24'($urandom));
      evals = $urandom_range(1, 5);
      for (int i = 0; i < evals; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          qx = longint'(signed'(24'($urandom)));
        end else begin
          qx = longint'(x0) * 256 + longint'(h) * ($urandom_range(0, 2816) - 512);
        end
        send_item(($urandom_range(0, 15) == 0) ? ACT_NOP : ACT_EVAL,
                  16'($urandom), 16'($urandom), qx[23:0]);
      end
    end
  endtask

  // Result checking and receiver-side stalls.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (want_y.size() == 0) begin
        $display("%0t: unexpected result y=%0d status=%0d", $time, result_y_o, status_o);
        mismatches++;
      end else begin
        if (result_y_o !== want_y[0]) begin
          $display("%0t: result_y expected %0d actual %0d", $time, want_y[0], result_y_o);
          mismatches++;
        end
        if (status_o !== want_status[0]) begin
          $display("%0t: status expected %0d actual %0d", $time, want_status[0], status_o);
          mismatches++;
        end
        void'(want_y.pop_front());
        void'(want_status.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Watchdog on cycles in which no transaction completes on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_forward_difference_interpolator_core: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      lead_diag[k] = 0;
      trail_diag[k] = 0;
    end
    pts_loaded = 0;
    x_first = 0;
    x_second = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_few_points();
    test_zero_spacing();
    test_widest_spacing();
    test_full_table();
    test_unknown_action();
    wait_drained();
    test_backpressure();
    test_random_sets();
    wait_drained();
    repeat (450) @(posedge clk_i);
    if (mismatches == 0 && want_y.size() == 0) begin
      $display("tb_forward_difference_interpolator_core: clean");
    end else begin
      $display("tb_forward_difference_interpolator_core: errors");
    end
    $finish;
  end

endmodule
